// ===== sv/nae_pkg.sv =====
package nae_pkg;

	localparam int NUM_STATES_DEF  = 16;
	localparam int NUM_SYMBOLS_DEF = 4;

	localparam int MODE_W   = 2;
	localparam int STATE_W  = 4;
	localparam int SYMBOL_W = 2;
	localparam int SET_FW   = 16;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 16;

	// Number of rows and symbols the fixed fields can address
	localparam int MAX_ROWS = 1 << STATE_W;
	localparam int MAX_SYMS = 1 << SYMBOL_W;

	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SYMBOL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EMPTY  = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_START_STATE = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_FINAL_MASK  = 1'd1;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [STATE_W-1:0]  row_state;
		logic [SYMBOL_W-1:0] symbol;
		logic [SET_FW-1:0]   next_set;
		logic                last;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic [SET_FW-1:0] end_set;
	} result_t;

	typedef struct packed {
		logic                en;
		logic [STATE_W-1:0]  row;
		logic [SYMBOL_W-1:0] sym;
		logic [SET_FW-1:0]   data;
	} wr_cmd_t;

endpackage

// ===== sv/nae_state_row.sv =====
module nae_state_row import nae_pkg::*; #(
	parameter int ROW_IDX = 0,
	parameter int SYMS    = NUM_SYMBOLS_DEF,
	parameter int SET_W   = NUM_STATES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wr_cmd_t             wr,
	input  logic [SYMBOL_W-1:0] rd_sym,
	input  logic                active,
	output logic [SET_W-1:0]    succ
);

	localparam int SYM_AW = (SYMS > 1) ? $clog2(SYMS) : 1;

	logic [SET_W-1:0] word_q [SYMS];
	logic             hit;
	logic             rd_ok;

	assign hit   = wr.en && (wr.row == STATE_W'(ROW_IDX)) && (int'(wr.sym) < SYMS);
	assign rd_ok = int'(rd_sym) < SYMS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMS; i++) begin
				word_q[i] <= '0;
			end
		end else if (hit) begin
			word_q[wr.sym[SYM_AW-1:0]] <= wr.data[SET_W-1:0];
		end
	end

	// Contribute this state's successors only while it is active
	assign succ = (active && rd_ok) ? word_q[rd_sym[SYM_AW-1:0]] : '0;

endmodule

// ===== sv/nae_result_reg.sv =====
module nae_result_reg import nae_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t din,
	output logic    free,
	output logic    valid,
	input  logic    ready,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

// ===== sv/nfa_acceptance_engine.sv =====
// An accepted request is registered in the input stage; the set update, and the
// result load for a last symbol or empty query, follow as it leaves that stage.
// Throughput: one request per cycle while the result slot is not blocked.
// Reset clears the whole transition store (flip-flops), the active set, the
// string flag and both registers at once; no clearing pass follows.
module nfa_acceptance_engine import nae_pkg::*; #(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	localparam int SET_W = (NUM_STATES < MAX_ROWS) ? NUM_STATES : MAX_ROWS;
	localparam int SYMS  = (NUM_SYMBOLS < MAX_SYMS) ? NUM_SYMBOLS : MAX_SYMS;

	logic               valid_s1;
	item_t              item_s1;
	logic [STATE_W-1:0] start_q;
	logic [SET_FW-1:0]  final_q;
	logic [SET_W-1:0]   active_q;
	logic               in_string_q;

	logic               go;
	logic               free;
	logic               produce;
	logic [SET_W-1:0]   start_bit;
	logic [SET_W-1:0]   base;
	logic [SET_W-1:0]   next_c;
	logic [SET_W-1:0]   out_set;
	logic [SET_W-1:0]   succ [SET_W];
	wr_cmd_t            wr;
	result_t            res_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			final_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_STATE: start_q <= cfg_data[STATE_W-1:0];
				CFG_FINAL_MASK:  final_q <= cfg_data[SET_FW-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: hold a request while the result slot is blocked
	assign go         = valid_s1 && free;
	assign item_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		for (int i = 0; i < SET_W; i++) begin
			start_bit[i] = (start_q == STATE_W'(i));
		end
	end

	assign base = in_string_q ? active_q : start_bit;

	assign wr.en   = go && (item_s1.mode == MODE_WRITE);
	assign wr.row  = item_s1.row_state;
	assign wr.sym  = item_s1.symbol;
	assign wr.data = item_s1.next_set;

	for (genvar r = 0; r < SET_W; r++) begin : g_row
		nae_state_row #(
			.ROW_IDX (r),
			.SYMS    (SYMS),
			.SET_W   (SET_W)
		) u_row (
			.clk    (clk),
			.arst_n (arst_n),
			.wr     (wr),
			.rd_sym (item_s1.symbol),
			.active (base[r]),
			.succ   (succ[r])
		);
	end

	always_comb begin
		next_c = '0;
		for (int i = 0; i < SET_W; i++) begin
			next_c = next_c | succ[i];
		end
	end

	always_comb begin
		case (item_s1.mode)
			MODE_SYMBOL: produce = go && item_s1.last;
			MODE_EMPTY:  produce = go;
			default:     produce = 1'b0;
		endcase
	end

	assign out_set      = (item_s1.mode == MODE_EMPTY) ? start_bit : next_c;
	assign res_c.accepted = |(out_set & final_q[SET_W-1:0]);
	assign res_c.end_set  = SET_FW'(out_set);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			in_string_q <= 1'b0;
		end else if (go) begin
			case (item_s1.mode)
				MODE_SYMBOL: begin
					active_q    <= next_c;
					in_string_q <= !item_s1.last;
				end
				MODE_EMPTY: begin
					in_string_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	nae_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (produce),
		.din    (res_c),
		.free   (free),
		.valid  (result_valid),
		.ready  (result_ready),
		.data   (result)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && result_valid && !result_ready))
		else $error("input stalled without a blocked result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> result_valid)
		else $error("result missing after a final symbol or empty query");

	a_string_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(go && item_s1.mode == MODE_SYMBOL && item_s1.last) |=> !in_string_q)
		else $error("string still open after its last symbol");

	a_empty_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(go && item_s1.mode == MODE_EMPTY) |=> $onehot0(result.end_set))
		else $error("empty query returned more than the start state");

	a_accept_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.accepted) |-> (result.end_set != '0))
		else $error("accepted with an empty end set");

endmodule
